@@ rtl/ddim_pkg.sv @@
// Shared types and constants for the DDIM denoise step block.
// Depends on nothing; the other files that use it refer to it by scoped names.
`default_nettype none
package ddim_pkg;

    // Wide enough for any table length in the supported range (up to 4096)
    localparam int CNT_W = 13;

    localparam logic [1:0] REG_BETA_START = 2'd0;
    localparam logic [1:0] REG_BETA_END   = 2'd1;
    localparam logic [1:0] REG_TRAIN      = 2'd2;
    localparam logic [1:0] REG_INFER      = 2'd3;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_SQRT_S,
        OP_SQRT_E,
        OP_DIV_STEP,
        OP_DIV_SPACE,
        OP_BUILD_INIT,
        OP_MUL_VAL,
        OP_MUL_CUM,
        OP_WRITE,
        OP_RD_A,
        OP_SQRT_AN,
        OP_SQRT_BN,
        OP_RD_P,
        OP_SQRT_AP,
        OP_SQRT_BP,
        OP_MUL_NUM,
        OP_DIV_X0,
        OP_MUL_ACC1,
        OP_MUL_ACC2,
        OP_SUM,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic table_ready;
        logic cache_hit;
        logic sq_done;
        logic dv_done;
        logic last_entry;
        logic ra_zero;
        logic out_busy;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/ddim_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Depends on nothing.
`default_nettype none
module ddim_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_operand,
    output logic             o_done,
    output logic [31:0]      o_root
);
    logic [63:0] r_x;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [35:0] rem2;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;
    logic [33:0] n_rem;

    always_comb begin
        rem2  = {r_rem, r_x[63:62]};
        trial = {2'b00, r_root, 2'b01};
        diff  = rem2 - trial;
        ge    = rem2 >= trial;
        n_rem = ge ? diff[33:0] : rem2[33:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_operand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[61:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

@@ rtl/ddim_div.sv @@
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// Depends on nothing.
`default_nettype none
module ddim_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quot,
    output logic [31:0]      o_rem
);
    logic [63:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_d;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] rem2;
    logic [32:0] sub;
    logic        ge;

    always_comb begin
        rem2 = {r_r, r_q[63]};
        sub  = rem2 - {1'b0, r_d};
        ge   = rem2 >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[62:0], ge};
            r_r <= ge ? sub[31:0] : rem2[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

@@ rtl/ddim_dp.sv @@
// Datapath: alpha table memory, coefficient cache, shared multiplier, root and divide units.
// Depends on ddim_pkg, ddim_isqrt and ddim_div.
`default_nettype none
module ddim_dp #(
    parameter int MAX_TRAIN_STEPS = 1024
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ddim_pkg::t_op               i_op,
    output ddim_pkg::t_stat                  o_stat,
    input  wire logic                        i_cfg_wr,
    input  wire logic [23:0]                 i_beta_start,
    input  wire logic [23:0]                 i_beta_end,
    input  wire logic [ddim_pkg::CNT_W-1:0]  i_eff_train,
    input  wire logic [10:0]                 i_eff_infer,
    input  wire logic [9:0]                  i_timestep,
    input  wire logic signed [31:0]          i_noise_value,
    input  wire logic signed [31:0]          i_latent_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [31:0]               o_previous_latent,
    output logic                             o_saturated
);
    localparam int AW = $clog2(MAX_TRAIN_STEPS);
    localparam int CW = ddim_pkg::CNT_W;

    // latched request
    logic [9:0]         r_t;
    logic signed [31:0] r_eps;
    logic signed [31:0] r_cur;

    // schedule build
    logic [23:0]   r_s;
    logic [23:0]   r_e;
    logic          r_dir;
    logic [23:0]   r_qd;
    logic [CW-1:0] r_rd;
    logic [CW-1:0] r_space;
    logic [23:0]   r_val;
    logic [CW-1:0] r_rem;
    logic [30:0]   r_cum;
    logic [CW-1:0] r_idx;
    logic          r_table_ready;

    logic [30:0] r_mem [MAX_TRAIN_STEPS];
    logic [30:0] r_mq;
    logic        r_rd_one;
    logic        r_rd_zero;
    logic [30:0] r_aval;

    // coefficient cache
    logic [10:0] r_cached;
    logic [30:0] r_ran;
    logic [30:0] r_rbn;
    logic [30:0] r_rap;
    logic [30:0] r_rbp;

    // per-element evaluation
    logic signed [65:0] r_prod;
    logic signed [63:0] r_acc;
    logic               r_num_neg;
    logic               r_num_nz;
    logic signed [31:0] r_x0;
    logic               r_flag;
    logic               r_ovalid;
    logic signed [31:0] r_out;
    logic               r_osat;

    ddim_pkg::t_op r_sq_dst;
    ddim_pkg::t_op r_dv_dst;

    logic               sq_start;
    logic [63:0]        sq_operand;
    logic               sq_done;
    logic [31:0]        sq_root;
    logic               dv_start;
    logic [63:0]        dv_dividend;
    logic [31:0]        dv_divisor;
    logic               dv_done;
    logic [63:0]        dv_quot;
    logic [31:0]        dv_rem;

    logic [23:0]        diff;
    logic [CW-1:0]      nm1;
    logic [24:0]        beta_sum;
    logic [24:0]        alpha;
    logic [55:0]        cum_sum;
    logic [30:0]        cum_n;
    logic [CW:0]        rem_sum;
    logic               carry;
    logic [CW-1:0]      rem_n;
    logic [23:0]        inc;
    logic [30:0]        aval_sel;
    logic [CW:0]        pv;
    logic [CW-1:0]      rd_idx;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mul_en;
    logic signed [63:0] num;
    logic [63:0]        num_mag;
    logic signed [31:0] x0_n;
    logic               x0_sat;
    logic               acc_neg;
    logic [63:0]        acc_mag;
    logic [63:0]        rnd_sum;
    logic [33:0]        rnd;
    logic signed [31:0] res;
    logic               res_sat;

    ddim_isqrt u_isqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sq_start),
        .i_operand (sq_operand),
        .o_done    (sq_done),
        .o_root    (sq_root)
    );

    ddim_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dv_start),
        .i_dividend (dv_dividend),
        .i_divisor  (dv_divisor),
        .o_done     (dv_done),
        .o_quot     (dv_quot),
        .o_rem      (dv_rem)
    );

    always_comb begin
        // direction comes straight from the roots; r_dir is loaded in the same cycle
        diff     = (r_e >= r_s) ? (r_e - r_s) : (r_s - r_e);
        nm1      = i_eff_train - CW'(1);
        beta_sum = 25'(r_prod[47:24]) + 25'(r_prod[23]);
        alpha    = 25'h100_0000 - beta_sum;
        cum_sum  = r_prod[55:0] + 56'h80_0000;
        cum_n    = cum_sum[54:24];
        rem_sum  = {1'b0, r_rem} + {1'b0, r_rd};
        carry    = rem_sum >= {1'b0, nm1};
        rem_n    = carry ? CW'(rem_sum - {1'b0, nm1}) : rem_sum[CW-1:0];
        inc      = r_qd + 24'(carry);
        aval_sel = r_rd_one ? ddim_pkg::ONE_Q30 : (r_rd_zero ? 31'd0 : r_mq);
        pv       = {4'b0000, r_t} - {1'b0, r_space};
        rd_idx   = (i_op == ddim_pkg::OP_RD_P) ? pv[CW-1:0] : {3'b000, r_t};
    end

    // root unit operand select
    always_comb begin
        sq_start   = 1'b1;
        sq_operand = '0;
        case (i_op)
            ddim_pkg::OP_SQRT_S:  sq_operand = {16'd0, i_beta_start, 24'd0};
            ddim_pkg::OP_SQRT_E:  sq_operand = {16'd0, i_beta_end, 24'd0};
            ddim_pkg::OP_SQRT_AN: sq_operand = {3'b000, aval_sel, 30'd0};
            ddim_pkg::OP_SQRT_AP: sq_operand = {3'b000, aval_sel, 30'd0};
            ddim_pkg::OP_SQRT_BN: sq_operand = {3'b000, ddim_pkg::ONE_Q30 - r_aval, 30'd0};
            ddim_pkg::OP_SQRT_BP: sq_operand = {3'b000, ddim_pkg::ONE_Q30 - r_aval, 30'd0};
            default:              sq_start   = 1'b0;
        endcase
    end

    // num = cur * 2^30 - root_beta_now * eps
    always_comb begin
        num     = {{2{r_cur[31]}}, r_cur, 30'd0} - r_prod[63:0];
        num_mag = num[63] ? 64'(-num) : num;
    end

    always_comb begin
        dv_start    = 1'b0;
        dv_dividend = '0;
        dv_divisor  = '0;
        case (i_op)
            ddim_pkg::OP_DIV_STEP: begin
                dv_start    = 1'b1;
                dv_dividend = {40'd0, diff};
                dv_divisor  = 32'(nm1);
            end
            ddim_pkg::OP_DIV_SPACE: begin
                dv_start    = 1'b1;
                dv_dividend = 64'(i_eff_train);
                dv_divisor  = {21'd0, i_eff_infer};
            end
            ddim_pkg::OP_DIV_X0: begin
                dv_start    = r_ran != 31'd0;
                dv_dividend = num_mag;
                dv_divisor  = {1'b0, r_ran};
            end
            default: dv_start = 1'b0;
        endcase
    end

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (i_op)
            ddim_pkg::OP_MUL_VAL: begin
                mul_a = {9'd0, r_val};
                mul_b = {9'd0, r_val};
            end
            ddim_pkg::OP_MUL_CUM: begin
                mul_a = {2'b00, r_cum};
                mul_b = {8'd0, alpha};
            end
            ddim_pkg::OP_MUL_NUM: begin
                mul_a = {2'b00, r_rbn};
                mul_b = {r_eps[31], r_eps};
            end
            ddim_pkg::OP_MUL_ACC1: begin
                mul_a = {2'b00, r_rap};
                mul_b = {r_x0[31], r_x0};
            end
            ddim_pkg::OP_MUL_ACC2: begin
                mul_a = {2'b00, r_rbp};
                mul_b = {r_eps[31], r_eps};
            end
            default: mul_en = 1'b0;
        endcase
    end

    // truncate quotient toward zero, then clip to 32 bits
    always_comb begin
        x0_sat = 1'b0;
        if (r_num_neg) begin
            if (dv_quot > 64'h8000_0000) begin
                x0_n   = 32'sh8000_0000;
                x0_sat = 1'b1;
            end else begin
                x0_n = 32'(-dv_quot[31:0]);
            end
        end else begin
            if (dv_quot > 64'h7FFF_FFFF) begin
                x0_n   = 32'sh7FFF_FFFF;
                x0_sat = 1'b1;
            end else begin
                x0_n = dv_quot[31:0];
            end
        end
    end

    // round half away from zero at 2^30, clip; a zero divisor saturates by the sign of num
    always_comb begin
        acc_neg = r_acc[63];
        acc_mag = acc_neg ? 64'(-r_acc) : r_acc;
        rnd_sum = acc_mag + 64'h2000_0000;
        rnd     = rnd_sum[63:30];
        res_sat = 1'b0;
        if (r_ran == 31'd0) begin
            res_sat = 1'b1;
            if (!r_num_nz) begin
                res = '0;
            end else if (r_num_neg) begin
                res = 32'sh8000_0000;
            end else begin
                res = 32'sh7FFF_FFFF;
            end
        end else if (acc_neg) begin
            if (rnd > 34'h0_8000_0000) begin
                res     = 32'sh8000_0000;
                res_sat = 1'b1;
            end else begin
                res = 32'(-rnd[31:0]);
            end
        end else begin
            if (rnd > 34'h0_7FFF_FFFF) begin
                res     = 32'sh7FFF_FFFF;
                res_sat = 1'b1;
            end else begin
                res = rnd[31:0];
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_ready <= 1'b0;
            r_cached      <= '1;
            r_ovalid      <= 1'b0;
            r_ran         <= '0;
            r_rbn         <= '0;
            r_rap         <= '0;
            r_rbp         <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_table_ready <= 1'b0;
                r_cached      <= '1;
            end else begin
                if (i_op == ddim_pkg::OP_WRITE && r_idx == nm1) begin
                    r_table_ready <= 1'b1;
                end
                if (i_op == ddim_pkg::OP_RD_A) begin
                    r_cached <= {1'b0, r_t};
                end
            end
            if (sq_done) begin
                case (r_sq_dst)
                    ddim_pkg::OP_SQRT_AN: r_ran <= sq_root[30:0];
                    ddim_pkg::OP_SQRT_BN: r_rbn <= sq_root[30:0];
                    ddim_pkg::OP_SQRT_AP: r_rap <= sq_root[30:0];
                    ddim_pkg::OP_SQRT_BP: r_rbp <= sq_root[30:0];
                    default:              r_rbp <= r_rbp;
                endcase
            end
            if (i_op == ddim_pkg::OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (sq_start) begin
            r_sq_dst <= i_op;
        end
        if (dv_start) begin
            r_dv_dst <= i_op;
        end
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (sq_done) begin
            if (r_sq_dst == ddim_pkg::OP_SQRT_S) begin
                r_s <= sq_root[23:0];
            end
            if (r_sq_dst == ddim_pkg::OP_SQRT_E) begin
                r_e <= sq_root[23:0];
            end
        end
        if (dv_done) begin
            case (r_dv_dst)
                ddim_pkg::OP_DIV_STEP: begin
                    r_qd <= dv_quot[23:0];
                    r_rd <= dv_rem[CW-1:0];
                end
                ddim_pkg::OP_DIV_SPACE: r_space <= dv_quot[CW-1:0];
                ddim_pkg::OP_DIV_X0: begin
                    r_x0   <= x0_n;
                    r_flag <= r_flag | x0_sat;
                end
                default: r_x0 <= r_x0;
            endcase
        end
        case (i_op)
            ddim_pkg::OP_LATCH: begin
                r_t    <= i_timestep;
                r_eps  <= i_noise_value;
                r_cur  <= i_latent_value;
                r_flag <= 1'b0;
            end
            ddim_pkg::OP_DIV_STEP: r_dir <= r_e >= r_s;
            ddim_pkg::OP_BUILD_INIT: begin
                r_val <= r_s;
                r_rem <= '0;
                r_idx <= '0;
                r_cum <= ddim_pkg::ONE_Q30;
            end
            ddim_pkg::OP_WRITE: begin
                r_mem[r_idx[AW-1:0]] <= cum_n;
                r_cum <= cum_n;
                r_idx <= r_idx + CW'(1);
                r_rem <= rem_n;
                r_val <= r_dir ? (r_val + inc) : (r_val - inc);
            end
            ddim_pkg::OP_RD_A: begin
                r_mq      <= r_mem[rd_idx[AW-1:0]];
                r_rd_one  <= 1'b0;
                r_rd_zero <= {3'b000, r_t} >= i_eff_train;
            end
            ddim_pkg::OP_RD_P: begin
                r_mq      <= r_mem[rd_idx[AW-1:0]];
                r_rd_one  <= pv[CW];
                r_rd_zero <= !pv[CW] && (pv[CW-1:0] >= i_eff_train);
            end
            ddim_pkg::OP_SQRT_AN: r_aval <= aval_sel;
            ddim_pkg::OP_SQRT_AP: r_aval <= aval_sel;
            ddim_pkg::OP_DIV_X0: begin
                r_num_neg <= num[63];
                r_num_nz  <= num != 64'sd0;
            end
            ddim_pkg::OP_MUL_ACC2: r_acc <= r_prod[63:0];
            ddim_pkg::OP_SUM:      r_acc <= r_acc + r_prod[63:0];
            ddim_pkg::OP_OUT: begin
                r_out  <= res;
                r_osat <= r_flag | res_sat;
            end
            default: r_acc <= r_acc;
        endcase
    end

    always_comb begin
        o_stat.table_ready = r_table_ready;
        o_stat.cache_hit   = r_cached == {1'b0, r_t};
        o_stat.sq_done     = sq_done;
        o_stat.dv_done     = dv_done;
        o_stat.last_entry  = r_idx == nm1;
        o_stat.ra_zero     = r_ran == 31'd0;
        o_stat.out_busy    = r_ovalid && !i_out_ready;
    end

    assign o_out_valid       = r_ovalid;
    assign o_previous_latent = r_out;
    assign o_saturated       = r_osat;
endmodule
`default_nettype wire

@@ rtl/ddim_ctrl.sv @@
// Sequencer for table build, coefficient load and per-element evaluation.
// Depends on ddim_pkg.
`default_nettype none
module ddim_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire ddim_pkg::t_stat i_stat,
    output ddim_pkg::t_op        o_op
);
    typedef enum logic [30:0] {
        S_IDLE  = 31'b1 << 0,
        S_CHECK = 31'b1 << 1,
        S_BSQS  = 31'b1 << 2,
        S_BSQSW = 31'b1 << 3,
        S_BSQE  = 31'b1 << 4,
        S_BSQEW = 31'b1 << 5,
        S_BDV1  = 31'b1 << 6,
        S_BDV1W = 31'b1 << 7,
        S_BDV2  = 31'b1 << 8,
        S_BDV2W = 31'b1 << 9,
        S_BINIT = 31'b1 << 10,
        S_BMV   = 31'b1 << 11,
        S_BMC   = 31'b1 << 12,
        S_BWR   = 31'b1 << 13,
        S_CRDA  = 31'b1 << 14,
        S_CSAN  = 31'b1 << 15,
        S_CSANW = 31'b1 << 16,
        S_CSBN  = 31'b1 << 17,
        S_CSBNW = 31'b1 << 18,
        S_CRDP  = 31'b1 << 19,
        S_CSAP  = 31'b1 << 20,
        S_CSAPW = 31'b1 << 21,
        S_CSBP  = 31'b1 << 22,
        S_CSBPW = 31'b1 << 23,
        S_EMN   = 31'b1 << 24,
        S_EDV   = 31'b1 << 25,
        S_EDVW  = 31'b1 << 26,
        S_EM1   = 31'b1 << 27,
        S_EM2   = 31'b1 << 28,
        S_ESUM  = 31'b1 << 29,
        S_EOUT  = 31'b1 << 30
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_op    = ddim_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = ddim_pkg::OP_LATCH;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.table_ready) begin
                    n_state = S_BSQS;
                end else if (!i_stat.cache_hit) begin
                    n_state = S_CRDA;
                end else begin
                    n_state = S_EMN;
                end
            end
            S_BSQS: begin
                o_op    = ddim_pkg::OP_SQRT_S;
                n_state = S_BSQSW;
            end
            S_BSQSW: if (i_stat.sq_done) n_state = S_BSQE;
            S_BSQE: begin
                o_op    = ddim_pkg::OP_SQRT_E;
                n_state = S_BSQEW;
            end
            S_BSQEW: if (i_stat.sq_done) n_state = S_BDV1;
            S_BDV1: begin
                o_op    = ddim_pkg::OP_DIV_STEP;
                n_state = S_BDV1W;
            end
            S_BDV1W: if (i_stat.dv_done) n_state = S_BDV2;
            S_BDV2: begin
                o_op    = ddim_pkg::OP_DIV_SPACE;
                n_state = S_BDV2W;
            end
            S_BDV2W: if (i_stat.dv_done) n_state = S_BINIT;
            S_BINIT: begin
                o_op    = ddim_pkg::OP_BUILD_INIT;
                n_state = S_BMV;
            end
            S_BMV: begin
                o_op    = ddim_pkg::OP_MUL_VAL;
                n_state = S_BMC;
            end
            S_BMC: begin
                o_op    = ddim_pkg::OP_MUL_CUM;
                n_state = S_BWR;
            end
            S_BWR: begin
                o_op    = ddim_pkg::OP_WRITE;
                n_state = i_stat.last_entry ? S_CRDA : S_BMV;
            end
            S_CRDA: begin
                o_op    = ddim_pkg::OP_RD_A;
                n_state = S_CSAN;
            end
            S_CSAN: begin
                o_op    = ddim_pkg::OP_SQRT_AN;
                n_state = S_CSANW;
            end
            S_CSANW: if (i_stat.sq_done) n_state = S_CSBN;
            S_CSBN: begin
                o_op    = ddim_pkg::OP_SQRT_BN;
                n_state = S_CSBNW;
            end
            S_CSBNW: if (i_stat.sq_done) n_state = S_CRDP;
            S_CRDP: begin
                o_op    = ddim_pkg::OP_RD_P;
                n_state = S_CSAP;
            end
            S_CSAP: begin
                o_op    = ddim_pkg::OP_SQRT_AP;
                n_state = S_CSAPW;
            end
            S_CSAPW: if (i_stat.sq_done) n_state = S_CSBP;
            S_CSBP: begin
                o_op    = ddim_pkg::OP_SQRT_BP;
                n_state = S_CSBPW;
            end
            S_CSBPW: if (i_stat.sq_done) n_state = S_EMN;
            S_EMN: begin
                o_op    = ddim_pkg::OP_MUL_NUM;
                n_state = S_EDV;
            end
            S_EDV: begin
                // zero divisor: skip the divide, output saturates
                o_op    = ddim_pkg::OP_DIV_X0;
                n_state = i_stat.ra_zero ? S_EOUT : S_EDVW;
            end
            S_EDVW: if (i_stat.dv_done) n_state = S_EM1;
            S_EM1: begin
                o_op    = ddim_pkg::OP_MUL_ACC1;
                n_state = S_EM2;
            end
            S_EM2: begin
                o_op    = ddim_pkg::OP_MUL_ACC2;
                n_state = S_ESUM;
            end
            S_ESUM: begin
                o_op    = ddim_pkg::OP_SUM;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                // hold until the output register frees up
                if (!i_stat.out_busy) begin
                    o_op    = ddim_pkg::OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;
endmodule
`default_nettype wire

@@ rtl/ddim_denoise_step.sv @@
// A request that hits the coefficient cache goes straight to evaluation; a miss first does
// two table reads and four square roots. The first request after reset or a register write
// also rebuilds the table: two square roots, two divides, then a square, a cumulative
// multiply and a write per entry. One request in flight at a time; a finished result waits
// in the output register. Reset (i_rst_n, synchronous) restores default registers, empties
// cache and table valid flag. Depends on ddim_pkg, ddim_ctrl and ddim_dp.
`default_nettype none
module ddim_denoise_step #(
    parameter int MAX_TRAIN_STEPS = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [9:0]         i_timestep,
    input  wire logic signed [31:0] i_noise_value,
    input  wire logic signed [31:0] i_latent_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_previous_latent,
    output logic                    o_saturated
);
    localparam int CW = ddim_pkg::CNT_W;

    logic [23:0]   r_beta_start;
    logic [23:0]   r_beta_end;
    logic [10:0]   r_train_steps;
    logic [10:0]   r_infer_steps;
    logic          cfg_wr;
    logic [CW-1:0] ts_ext;
    logic [CW-1:0] eff_train;
    logic [10:0]   eff_infer;

    ddim_pkg::t_op   op;
    ddim_pkg::t_stat stat;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta_start  <= 24'd14261;
            r_beta_end    <= 24'd201327;
            r_train_steps <= 11'd1000;
            r_infer_steps <= 11'd50;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                ddim_pkg::REG_BETA_START: r_beta_start  <= pwdata[23:0];
                ddim_pkg::REG_BETA_END:   r_beta_end    <= pwdata[23:0];
                ddim_pkg::REG_TRAIN:      r_train_steps <= pwdata[10:0];
                ddim_pkg::REG_INFER:      r_infer_steps <= pwdata[10:0];
                default:                  r_infer_steps <= r_infer_steps;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ddim_pkg::REG_BETA_START: prdata = {8'd0, r_beta_start};
            ddim_pkg::REG_BETA_END:   prdata = {8'd0, r_beta_end};
            ddim_pkg::REG_TRAIN:      prdata = {21'd0, r_train_steps};
            ddim_pkg::REG_INFER:      prdata = {21'd0, r_infer_steps};
            default:                  prdata = '0;
        endcase
    end

    // clamp table length to [2, MAX_TRAIN_STEPS]; zero inference steps acts as one
    always_comb begin
        ts_ext = CW'(r_train_steps);
        if (ts_ext < CW'(2)) begin
            eff_train = CW'(2);
        end else if (ts_ext > CW'(MAX_TRAIN_STEPS)) begin
            eff_train = CW'(MAX_TRAIN_STEPS);
        end else begin
            eff_train = ts_ext;
        end
        eff_infer = (r_infer_steps == 11'd0) ? 11'd1 : r_infer_steps;
    end

    ddim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_op       (op)
    );

    ddim_dp #(
        .MAX_TRAIN_STEPS (MAX_TRAIN_STEPS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (op),
        .o_stat            (stat),
        .i_cfg_wr          (cfg_wr),
        .i_beta_start      (r_beta_start),
        .i_beta_end        (r_beta_end),
        .i_eff_train       (eff_train),
        .i_eff_infer       (eff_infer),
        .i_timestep        (i_timestep),
        .i_noise_value     (i_noise_value),
        .i_latent_value    (i_latent_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_previous_latent (o_previous_latent),
        .o_saturated       (o_saturated)
    );
endmodule
`default_nettype wire
